// ===== rtl/rlts_pkg.sv =====
// Package for the router list top priority select block.
// Holds the function codes, the register map and the controller/datapath structs.
// No dependencies.
package rlts_pkg;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_OFFER = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam int        PADDR_W       = 3;
	localparam int        PDATA_W       = 32;
	localparam logic      REG_MAX_SLOTS = 1'b0;
	localparam logic [5:0] MAX_SLOTS_RST = 6'd32;

	localparam logic [7:0] CONN_BIT = 8'h80;

	typedef struct packed {
		logic latch;
		logic clear_fill;
		logic append;
		logic scan_start;
		logic scan_step;
		logic replace;
		logic read_issue;
		logic read_capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       qualify;
		logic       room;
		logic       cap_zero;
		logic       scan_last;
	} stat_t;

endpackage

// ===== rtl/rlts_if.sv =====
// Handshake interfaces for the router list top priority select block.
// rlts_req_if carries input words, rlts_rsp_if carries result words.
// No dependencies.
interface rlts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] node_addr;
	logic [6:0]  priority_req;
	logic        is_router;
	logic        connected;
	logic        on_device;
	logic [4:0]  read_index;

	modport source (output valid, func, node_addr, priority_req, is_router, connected,
		on_device, read_index, input ready);
	modport sink (input valid, func, node_addr, priority_req, is_router, connected,
		on_device, read_index, output ready);
endinterface

interface rlts_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  list_count;
	logic        written;
	logic [4:0]  written_slot;
	logic [15:0] slot_addr;
	logic [7:0]  slot_info;

	modport source (output valid, list_count, written, written_slot, slot_addr, slot_info,
		input ready);
	modport sink (input valid, list_count, written, written_slot, slot_addr, slot_info,
		output ready);
endinterface

// ===== rtl/rlts_cfg.sv =====
// APB register file of the router list top priority select block.
// Holds max_slots. Depends on rlts_pkg.
module rlts_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rlts_pkg::PADDR_W-1:0]   paddr,
	input  logic [rlts_pkg::PDATA_W-1:0]   pwdata,
	output logic [rlts_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [5:0]                     max_slots
);

	logic [5:0] max_slots_q;
	logic       hit;

	// Registers are word aligned; the low address bits are ignored.
	assign hit = (paddr[2] == rlts_pkg::REG_MAX_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q <= rlts_pkg::MAX_SLOTS_RST;
		end else if (psel && penable && pwrite && hit) begin
			max_slots_q <= pwdata[5:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = hit ? {{(rlts_pkg::PDATA_W-6){1'b0}}, max_slots_q} : '0;
	assign max_slots = max_slots_q;

endmodule

// ===== rtl/rlts_ctrl.sv =====
// Controller of the router list top priority select block.
// Sequences accept, append, minimum scan, replace, read and result hand-off.
// Depends on rlts_pkg.
module rlts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rlts_pkg::stat_t   stat,
	output rlts_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_RDWAIT = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nx  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_nx = ST_DONE;
				case (stat.func)
					rlts_pkg::FUNC_START: cmd.clear_fill = 1'b1;
					rlts_pkg::FUNC_OFFER: begin
						if (stat.qualify && stat.room) begin
							cmd.append = 1'b1;
						end else if (stat.qualify && !stat.cap_zero) begin
							cmd.scan_start = 1'b1;
							state_nx       = ST_SCAN;
						end
					end
					rlts_pkg::FUNC_READ: begin
						cmd.read_issue = 1'b1;
						state_nx       = ST_RDWAIT;
					end
					default: state_nx = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nx = ST_DECIDE;
			ST_DECIDE: begin
				cmd.replace = 1'b1;
				state_nx    = ST_DONE;
			end
			ST_RDWAIT: begin
				cmd.read_capture = 1'b1;
				state_nx         = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/rlts_dp.sv =====
// Datapath of the router list top priority select block.
// Holds the slot memory, fill count, the minimum scan and the result registers.
// Depends on rlts_pkg.
module rlts_dp #(
	parameter int SLOTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rlts_pkg::cmd_t    cmd,
	output rlts_pkg::stat_t   stat,
	input  logic [5:0]        max_slots,
	input  logic [1:0]        func,
	input  logic [15:0]       node_addr,
	input  logic [6:0]        priority_req,
	input  logic              is_router,
	input  logic              connected,
	input  logic              on_device,
	input  logic [4:0]        read_index,
	output logic [5:0]        list_count,
	output logic              written,
	output logic [4:0]        written_slot,
	output logic [15:0]       slot_addr,
	output logic [7:0]        slot_info
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW = (SW > 6) ? SW : 6;
	localparam logic [5:0] CAP_LIMIT = 6'((SLOTS > 63) ? 63 : SLOTS);

	logic [23:0] mem_q [SLOTS];
	logic [23:0] rdata_q;

	logic [1:0]  func_q;
	logic [15:0] addr_q;
	logic [6:0]  prio_q;
	logic        conn_q;
	logic        qual_q;
	logic [4:0]  ridx_q;

	logic [5:0]  fill_q;
	logic [5:0]  scan_idx_q;
	logic [5:0]  idx_s1;
	logic        rvalid_s1;
	logic [5:0]  best_idx_q;
	logic [7:0]  best_info_q;

	logic        res_written_q;
	logic [4:0]  res_wslot_q;
	logic [15:0] res_saddr_q;
	logic [7:0]  res_sinfo_q;

	logic [5:0]  out_count_q;
	logic        out_written_q;
	logic [4:0]  out_wslot_q;
	logic [15:0] out_saddr_q;
	logic [7:0]  out_sinfo_q;

	logic [5:0]    cap;
	logic          do_replace;
	logic          we;
	logic          re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [23:0]   wdata;
	logic          ridx_ok;

	assign cap        = (max_slots < CAP_LIMIT) ? max_slots : CAP_LIMIT;
	assign do_replace = cmd.replace && (best_info_q < {1'b0, prio_q});
	assign ridx_ok    = (32'(ridx_q) < SLOTS);

	assign we    = cmd.append || do_replace;
	assign waddr = cmd.append ? AW'(fill_q) : AW'(best_idx_q);
	assign wdata = {addr_q, (conn_q ? rlts_pkg::CONN_BIT : 8'h00) | {1'b0, prio_q}};
	assign re    = cmd.scan_step || cmd.read_issue;
	assign raddr = cmd.scan_step ? AW'(scan_idx_q) : AW'(ridx_q);

	assign stat.func      = func_q;
	assign stat.qualify   = qual_q;
	assign stat.room      = (fill_q < cap);
	assign stat.cap_zero  = (cap == 6'd0);
	assign stat.scan_last = (scan_idx_q == cap - 6'd1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr[SW-1:0]] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr[SW-1:0]];
		end
	end

	// Item and result registers carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q        <= func;
			addr_q        <= node_addr;
			prio_q        <= priority_req;
			conn_q        <= connected;
			qual_q        <= on_device && is_router;
			ridx_q        <= read_index;
			res_written_q <= 1'b0;
			res_wslot_q   <= '0;
			res_saddr_q   <= '0;
			res_sinfo_q   <= '0;
		end
		if (cmd.append) begin
			res_written_q <= 1'b1;
			res_wslot_q   <= fill_q[4:0];
		end
		if (do_replace) begin
			res_written_q <= 1'b1;
			res_wslot_q   <= best_idx_q[4:0];
		end
		if (cmd.read_capture && ridx_ok) begin
			res_saddr_q <= rdata_q[23:8];
			res_sinfo_q <= rdata_q[7:0];
		end
		if (cmd.load_out) begin
			out_count_q   <= fill_q;
			out_written_q <= res_written_q;
			out_wslot_q   <= res_wslot_q;
			out_saddr_q   <= res_saddr_q;
			out_sinfo_q   <= res_sinfo_q;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 6'd1;
		end
		idx_s1 <= scan_idx_q;
		// The first slot seeds the minimum; later ones win only when strictly smaller.
		if (rvalid_s1 && ((idx_s1 == 6'd0) || (rdata_q[7:0] < best_info_q))) begin
			best_idx_q  <= idx_s1;
			best_info_q <= rdata_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.scan_step;
			if (cmd.clear_fill) begin
				fill_q <= '0;
			end else if (cmd.append) begin
				fill_q <= fill_q + 6'd1;
			end
		end
	end

	assign list_count   = out_count_q;
	assign written      = out_written_q;
	assign written_slot = out_wslot_q;
	assign slot_addr    = out_saddr_q;
	assign slot_info    = out_sinfo_q;

endmodule

// ===== rtl/router_list_top_priority_select_unit.sv =====
// Router list top priority select: builds a bounded list of the best routers.
// Usage: words enter on req (func, neighbour record, read index) and each gives
// one word on rsp. func 0 empties the list, func 1 offers a neighbour, func 2
// reads one slot. The APB port holds max_slots at byte address 0.
// A start, an append or an unused code goes from accept through evaluation to
// the result; a read adds a wait for the memory data. An offer to a full list
// scans the first cap stored info bytes, one per cycle, through the single
// memory read port, where cap is min(max_slots, SLOTS), then decides on replace.
// One word is in work at a time; req.ready is high only while the unit waits.
// The result sits in an output register, so the next word is taken while a
// result still waits for rsp.ready; a stalled receiver holds that word, and
// the following one waits finished until the register is free.
// Reset clears the fill count and restores max_slots to 32; slot contents are
// left as they are and read back undefined until written.
// Depends on rlts_pkg, rlts_if, rlts_cfg, rlts_ctrl, rlts_dp.
module router_list_top_priority_select_unit #(
	parameter int SLOTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rlts_req_if.sink                       req,
	rlts_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rlts_pkg::PADDR_W-1:0]   paddr,
	input  logic [rlts_pkg::PDATA_W-1:0]   pwdata,
	output logic [rlts_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam logic [5:0] COUNT_MAX = 6'((SLOTS > 63) ? 63 : SLOTS);

	rlts_pkg::cmd_t  cmd;
	rlts_pkg::stat_t stat;
	logic [5:0]      max_slots;

	rlts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_slots (max_slots)
	);

	rlts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rlts_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.max_slots    (max_slots),
		.func         (req.func),
		.node_addr    (req.node_addr),
		.priority_req (req.priority_req),
		.is_router    (req.is_router),
		.connected    (req.connected),
		.on_device    (req.on_device),
		.read_index   (req.read_index),
		.list_count   (rsp.list_count),
		.written      (rsp.written),
		.written_slot (rsp.written_slot),
		.slot_addr    (rsp.slot_addr),
		.slot_info    (rsp.slot_info)
	);

	// An offer that wrote a slot never carries read data.
	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.written) |-> (rsp.slot_addr == 16'd0 && rsp.slot_info == 8'd0))
		else $error("written result carries slot read data");

	// The list never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.list_count <= COUNT_MAX))
		else $error("list count beyond slot count");

	// A new result only appears after the unit was busy with a word.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without a word in work");

endmodule

// ===== verif/tb_router_list_top_priority_select_unit.sv =====
`timescale 1ns / 100ps
// Testbench for router_list_top_priority_select_unit: a queue-fed driver, a result monitor
// and a built-in list model that predicts every result word, across capacity settings.
// Depends on rlts_pkg, rlts_if and the RTL of the unit.
module tb_router_list_top_priority_select_unit;

	localparam int SLOTS = 32;
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam logic [rlts_pkg::PADDR_W-1:0] CAP_ADDR = {rlts_pkg::REG_MAX_SLOTS, 2'b00};
	localparam int HOLD_CYCLES = 500;
	localparam int TAIL_CYCLES = 45;
	localparam int unsigned TIMEOUT_NS = 20_000_000;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] node_addr;
		logic [6:0]  prio;
		logic        is_router;
		logic        connected;
		logic        on_device;
		logic [4:0]  read_index;
	} nbr_word_t;

	typedef struct packed {
		logic [5:0]  list_count;
		logic        written;
		logic [4:0]  written_slot;
		logic [15:0] slot_addr;
		logic [7:0]  slot_info;
	} list_result_t;

	typedef struct packed {
		logic [SLOTS-1:0][15:0] addr;
		logic [SLOTS-1:0][7:0]  info;
		logic [SLOTS-1:0]       filled;
		logic [5:0]             fill;
		logic [5:0]             max_slots;
	} list_state_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rlts_pkg::PADDR_W-1:0] paddr;
	logic [rlts_pkg::PDATA_W-1:0] pwdata;
	logic [rlts_pkg::PDATA_W-1:0] prdata;
	logic pready;

	rlts_req_if req_bus();
	rlts_rsp_if rsp_bus();

	router_list_top_priority_select_unit #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// live follows the words the unit has taken; plan runs ahead while words are queued.
	list_state_t live;
	list_state_t plan;
	nbr_word_t pending_words[$];
	list_result_t expected_results[$];
	nbr_word_t cur_word;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	int queued_cnt;
	int offer_cnt;
	int accept_cnt;
	int errors;
	int n_stored;
	int n_reads;
	int n_settings;

	always #10 clk = ~clk;

	function automatic void update_list(inout list_state_t st, input nbr_word_t w,
		output list_result_t r);
		int cap;
		int slot;
		int best;
		int i;
		r = '0;
		slot = -1;
		cap = (st.max_slots < SLOTS) ? int'(st.max_slots) : SLOTS;
		case (w.func)
			rlts_pkg::FUNC_START: begin
				st.fill = '0;
			end
			rlts_pkg::FUNC_OFFER: begin
				if (w.on_device && w.is_router) begin
					if (st.fill < cap) begin
						slot = st.fill;
						st.fill = st.fill + 6'd1;
					end else if (cap > 0) begin
						// The first slot with the smallest info byte is the candidate.
						best = 0;
						for (i = 1; i < cap; i++)
							if (st.info[i] < st.info[best])
								best = i;
						if (st.info[best] < {1'b0, w.prio})
							slot = best;
					end
					if (slot >= 0) begin
						st.addr[slot] = w.node_addr;
						st.info[slot] = {w.connected, w.prio};
						st.filled[slot] = 1'b1;
						r.written = 1'b1;
						r.written_slot = slot[4:0];
					end
				end
			end
			rlts_pkg::FUNC_READ: begin
				r.slot_addr = st.addr[w.read_index];
				r.slot_info = st.info[w.read_index];
			end
			default: ;
		endcase
		r.list_count = st.fill;
	endfunction

	function automatic nbr_word_t word_of(logic [1:0] func, logic [15:0] addr, logic [6:0] prio,
		logic router, logic conn, logic dev, logic [4:0] idx);
		nbr_word_t w;
		w.func = func;
		w.node_addr = addr;
		w.prio = prio;
		w.is_router = router;
		w.connected = conn;
		w.on_device = dev;
		w.read_index = idx;
		return w;
	endfunction

	function automatic nbr_word_t rand_word();
		nbr_word_t w;
		int pick;
		w.node_addr = 16'($urandom);
		if ($urandom_range(9) == 0)
			w.node_addr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		// Half the priorities are small so that ties and near misses are common.
		w.prio = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
		w.connected = ($urandom_range(9) < 3);
		w.is_router = ($urandom_range(9) != 0);
		w.on_device = ($urandom_range(9) != 0);
		w.read_index = 5'($urandom_range(SLOTS - 1));
		pick = $urandom_range(99);
		if (pick < 2)
			w.func = rlts_pkg::FUNC_START;
		else if (pick < 72)
			w.func = rlts_pkg::FUNC_OFFER;
		else if (pick < 97)
			w.func = rlts_pkg::FUNC_READ;
		else
			w.func = FUNC_SPARE;
		// Reads go only to slots that have been written since reset.
		if (w.func == rlts_pkg::FUNC_READ) begin
			if (plan.filled == '0)
				w.func = rlts_pkg::FUNC_OFFER;
			else
				while (!plan.filled[w.read_index])
					w.read_index = w.read_index + 5'd1;
		end
		return w;
	endfunction

	task automatic queue_word(input nbr_word_t w);
		list_result_t unused;
		update_list(plan, w, unused);
		pending_words.push_back(w);
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (accept_cnt != queued_cnt || expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Called at a falling edge with the unit idle.
	task automatic set_capacity(input logic [5:0] cap);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CAP_ADDR;
		pwdata = $urandom;
		pwdata[5:0] = cap;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		live.max_slots = cap;
		plan.max_slots = cap;
		n_settings++;
	endtask

	task automatic run_phase(input logic [5:0] cap, input int idle_pct, input int stall_pct,
		input int n, input bit hold);
		int counted;
		nbr_word_t w;
		wait_drained();
		set_capacity(cap);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (hold)
			hold_reqs++;
		counted = 0;
		while (counted < n) begin
			w = rand_word();
			if (w.func != rlts_pkg::FUNC_OFFER || (w.on_device && w.is_router))
				counted++;
			queue_word(w);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// Sender: a new word goes out once the previous one has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || accept_cnt == offer_cnt) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_word = pending_words.pop_front();
				req_bus.func <= cur_word.func;
				req_bus.node_addr <= cur_word.node_addr;
				req_bus.priority_req <= cur_word.prio;
				req_bus.is_router <= cur_word.is_router;
				req_bus.connected <= cur_word.connected;
				req_bus.on_device <= cur_word.on_device;
				req_bus.read_index <= cur_word.read_index;
				req_bus.valid <= 1'b1;
				offer_cnt++;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here and started by the stimulus process.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		rsp_bus.ready <= arst_n && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		nbr_word_t w;
		list_result_t want;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				w = word_of(req_bus.func, req_bus.node_addr, req_bus.priority_req,
					req_bus.is_router, req_bus.connected, req_bus.on_device,
					req_bus.read_index);
				update_list(live, w, want);
				expected_results.push_back(want);
				accept_cnt++;
				if (want.written)
					n_stored++;
				if (w.func == rlts_pkg::FUNC_READ)
					n_reads++;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with none expected, actual count %0h slot %0h",
						$realtime, rsp_bus.list_count, rsp_bus.written_slot);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("list_count", want.list_count, rsp_bus.list_count);
					check_field("written", want.written, rsp_bus.written);
					check_field("written_slot", want.written_slot, rsp_bus.written_slot);
					check_field("slot_addr", want.slot_addr, rsp_bus.slot_addr);
					check_field("slot_info", want.slot_info, rsp_bus.slot_info);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d words queued and %0d taken", $realtime, queued_cnt,
			accept_cnt);
		$display("status: fail");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.func = rlts_pkg::FUNC_START;
		req_bus.node_addr = '0;
		req_bus.priority_req = '0;
		req_bus.is_router = 1'b0;
		req_bus.connected = 1'b0;
		req_bus.on_device = 1'b0;
		req_bus.read_index = '0;
		rsp_bus.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		queued_cnt = 0;
		offer_cnt = 0;
		accept_cnt = 0;
		errors = 0;
		n_stored = 0;
		n_reads = 0;
		n_settings = 0;
		live = '0;
		live.max_slots = rlts_pkg::MAX_SLOTS_RST;
		plan = live;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset capacity: extremes of address and priority, and records that are dropped.
		queue_word(word_of(rlts_pkg::FUNC_START, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h0000, 7'd0, 1'b1, 1'b0, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b1, 5'd31));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h1234, 7'd5, 1'b0, 1'b1, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'hABCD, 7'd9, 1'b1, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h4321, 7'd99, 1'b0, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b1, 5'd1));
		queue_word(word_of(FUNC_SPARE, 16'hFFFF, 7'd127, 1'b1, 1'b1, 1'b1, 5'd31));

		// A full list of two: replacement only when the smallest byte is below the priority.
		wait_drained();
		set_capacity(6'd2);
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h5A5A, 7'd1, 1'b1, 1'b0, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h0F0F, 7'd0, 1'b1, 1'b0, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'hA5A5, 7'd127, 1'b1, 1'b1, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));

		// Capacity below the fill count, where a connected byte blocks the top priority.
		wait_drained();
		set_capacity(6'd1);
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h1111, 7'd127, 1'b1, 1'b0, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd1));

		// Zero capacity never stores.
		wait_drained();
		set_capacity(6'd0);
		queue_word(word_of(rlts_pkg::FUNC_START, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h2222, 7'd50, 1'b1, 1'b1, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));

		// The register maximum is clipped to the slot count.
		wait_drained();
		set_capacity(6'd63);
		queue_word(word_of(rlts_pkg::FUNC_START, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_OFFER, 16'h3333, 7'd127, 1'b1, 1'b0, 1'b1, 5'd0));
		queue_word(word_of(rlts_pkg::FUNC_READ, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 5'd0));

		run_phase(6'd32, 0, 0, 230, 1'b1);
		run_phase(6'd7, 47, 0, 220, 1'b0);
		run_phase(6'd63, 0, 47, 230, 1'b0);
		run_phase(6'd1, 36, 36, 200, 1'b0);
		run_phase(6'($urandom_range(2, 31)), 47, 0, 220, 1'b0);
		run_phase(6'd0, 0, 47, 120, 1'b0);
		run_phase(6'd33, 36, 36, 230, 1'b0);
		run_phase(6'd32, 0, 0, 200, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d words, %0d stored offers and %0d slot reads", accept_cnt,
			n_stored, n_reads);
		$display("over %0d capacity writes, idle and stall phases and a long receiver hold.",
			n_settings);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
